/* rtl/rsd_pkg.sv */
// Package for the ruler span and diagonal block.
// Field widths, screen extents, register indexes, sequencer states and the clamp.
// No dependencies.
package rsd_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned SPAN_W  = 10;
    localparam int unsigned DIAG_W  = 11;
    localparam int unsigned NUM_W   = 11;
    localparam int unsigned SQ_W    = 21;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned LIM_W   = 13;

    localparam int unsigned X_EXTENT = 800;
    localparam int unsigned Y_EXTENT = 1024;

    localparam logic [LIM_W-1:0] X_LIM = LIM_W'(X_EXTENT - 1);
    localparam logic [LIM_W-1:0] Y_LIM = LIM_W'(Y_EXTENT - 1);

    localparam logic [IDX_W-1:0] CFG_X_STEP = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_Y_STEP = IDX_W'(1);

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(SPAN_W - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(DIAG_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ROOT,
        ST_DONE
    } state_t;

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W-1:0] v,
        input logic [LIM_W-1:0]   lim
    );
        logic [COORD_W-1:0] c;
        c = v;
        if ({{(LIM_W-COORD_W){1'b0}}, v} > lim)
        begin
            c = lim[COORD_W-1:0];
        end
        return c;
    endfunction

endpackage

/* rtl/ruler_span_and_diagonal.sv */
// Ruler span and diagonal: spans in steps (ceiling divide) and floor sqrt diagonal.
// Bit-serial divide, shift-add square sum and two-bits-a-cycle square root.
// Depends on rsd_pkg.
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  s_      | s_tvalid / s_tready      | s_tdata: down_x, down_y, up_x, up_y
//  m_      | m_tvalid / m_tready      | m_tdata: span_x, span_y, diagonal
//  cfg_    | cfg_valid / cfg_ready    | cfg_index, cfg_data (x_step, y_step)
//
// One word passes from accept to result through 11 divide steps (both spans at
// once), 10 multiply steps and 11 root steps, then the output register is loaded.
// Sequencer takes one word at a time; s_tready is high only while idle.
// The output register holds a finished word so the next one can be accepted
// while m_tready is low; the sequencer waits in ST_DONE only if both are full.
// rst_n clears control state and sets both steps to 1; cfg_ready is always high.
module ruler_span_and_diagonal (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // down_x[9:0], down_y[19:10], up_x[29:20], up_y[39:30]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // span_x[9:0], span_y[19:10], diagonal[30:20], zero[31]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import rsd_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [STEP_W-1:0] x_step_reg, y_step_reg;
    logic [STEP_W-1:0] x_step_eff, y_step_eff;

    logic [NUM_W-1:0]  num_x_reg, num_y_reg;
    logic [STEP_W-1:0] rem_x_reg, rem_y_reg;
    logic [SQ_W-1:0]   acc_reg;
    logic [SQ_W:0]     rad_reg;
    logic [11:0]       rrem_reg;
    logic [DIAG_W-1:0] root_reg;

    logic              out_valid_reg;
    logic [SPAN_W-1:0] span_x_reg, span_y_reg;
    logic [DIAG_W-1:0] diag_reg;

    logic in_accept;
    logic out_load;
    logic cnt_zero;

    // front end
    logic [COORD_W-1:0] dx, dy, ux, uy, diff_x, diff_y;
    logic [NUM_W-1:0]   num_x_init, num_y_init;

    // divide step
    logic [STEP_W:0]   sh_x, sh_y;
    logic              q_x, q_y;
    logic [STEP_W-1:0] rem_x_next, rem_y_next;

    // multiply step
    logic [SPAN_W-1:0] sx, sy;
    logic [SQ_W-1:0]   acc_next;

    // root step
    logic [13:0]       rr_sh, rr_trial;
    logic              r_bit;
    logic [13:0]       rr_diff;

    assign x_step_eff = (x_step_reg == '0) ? STEP_W'(1) : x_step_reg;
    assign y_step_eff = (y_step_reg == '0) ? STEP_W'(1) : y_step_reg;
    assign cnt_zero   = (cnt_reg == '0);
    assign in_accept  = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg <= STEP_W'(1);
            y_step_reg <= STEP_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_X_STEP)
            begin
                x_step_reg <= cfg_data;
            end
            else if (cfg_index == CFG_Y_STEP)
            begin
                y_step_reg <= cfg_data;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    always_comb
    begin
        cnt_next = cnt_reg - CNT_W'(1);
        priority if (in_accept)
        begin
            cnt_next = DIV_LAST;
        end
        else if (state_reg == ST_DIV && cnt_zero)
        begin
            cnt_next = MUL_LAST;
        end
        else if (state_reg == ST_MUL && cnt_zero)
        begin
            cnt_next = ROOT_LAST;
        end
        else if (state_reg == ST_IDLE || state_reg == ST_DONE || cnt_zero)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // front end: clamp, distance, numerator for the rounded-up quotient
    always_comb
    begin
        dx = clamp_coord(s_tdata[9:0],   X_LIM);
        dy = clamp_coord(s_tdata[19:10], Y_LIM);
        ux = clamp_coord(s_tdata[29:20], X_LIM);
        uy = clamp_coord(s_tdata[39:30], Y_LIM);
        diff_x = (dx > ux) ? (dx - ux) : (ux - dx);
        diff_y = (dy > uy) ? (dy - uy) : (uy - dy);
        num_x_init = {1'b0, diff_x} + {{(NUM_W-STEP_W){1'b0}}, x_step_eff} - NUM_W'(1);
        num_y_init = {1'b0, diff_y} + {{(NUM_W-STEP_W){1'b0}}, y_step_eff} - NUM_W'(1);
    end

    // restoring divide, one quotient bit a cycle
    always_comb
    begin
        sh_x = {rem_x_reg, num_x_reg[NUM_W-1]};
        sh_y = {rem_y_reg, num_y_reg[NUM_W-1]};
        q_x  = (sh_x >= {1'b0, x_step_eff});
        q_y  = (sh_y >= {1'b0, y_step_eff});
        rem_x_next = q_x ? STEP_W'(sh_x - {1'b0, x_step_eff}) : sh_x[STEP_W-1:0];
        rem_y_next = q_y ? STEP_W'(sh_y - {1'b0, y_step_eff}) : sh_y[STEP_W-1:0];
    end

    // shift-add square sum, multiplier bits msb first
    always_comb
    begin
        sx = num_x_reg[SPAN_W-1:0];
        sy = num_y_reg[SPAN_W-1:0];
        acc_next = {acc_reg[SQ_W-2:0], 1'b0}
                 + (sx[cnt_reg] ? {{(SQ_W-SPAN_W){1'b0}}, sx} : '0)
                 + (sy[cnt_reg] ? {{(SQ_W-SPAN_W){1'b0}}, sy} : '0);
    end

    // restoring square root, two radicand bits a cycle
    always_comb
    begin
        rr_sh    = {rrem_reg, rad_reg[SQ_W:SQ_W-1]};
        rr_trial = {1'b0, root_reg, 2'b01};
        r_bit    = (rr_sh >= rr_trial);
        rr_diff  = rr_sh - rr_trial;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            num_x_reg <= num_x_init;
            num_y_reg <= num_y_init;
            rem_x_reg <= '0;
            rem_y_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            num_x_reg <= {num_x_reg[NUM_W-2:0], q_x};
            num_y_reg <= {num_y_reg[NUM_W-2:0], q_y};
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
        end

        if (state_reg == ST_DIV)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == ST_MUL)
        begin
            acc_reg <= acc_next;
        end

        if (state_reg == ST_MUL)
        begin
            rad_reg  <= {1'b0, acc_next};
            rrem_reg <= '0;
            root_reg <= '0;
        end
        else if (state_reg == ST_ROOT)
        begin
            rad_reg  <= {rad_reg[SQ_W-2:0], 2'b00};
            rrem_reg <= r_bit ? rr_diff[11:0] : rr_sh[11:0];
            root_reg <= {root_reg[DIAG_W-2:0], r_bit};
        end

        if (out_load)
        begin
            span_x_reg <= num_x_reg[SPAN_W-1:0];
            span_y_reg <= num_y_reg[SPAN_W-1:0];
            diag_reg   <= root_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, diag_reg, span_y_reg, span_x_reg};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid || m_tready))
        else $error("output word overwritten while pending");

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_DIV && cnt_reg == DIV_LAST))
        else $error("accepted word did not start the divide");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result shown without finishing the root");

endmodule
